### hw/rtl/c2ns_pkg.sv
// ----------------------------------------------------------------------------
// c2ns_pkg
// Shared widths, constants and the division cell payload type.
// ----------------------------------------------------------------------------
`default_nettype none

package c2ns_pkg;

  localparam int CNT_W    = 64;
  localparam int FREQ_W   = 32;
  localparam int SCALE_W  = 30;
  localparam int HALF_W   = CNT_W / 2;
  localparam int PPROD_W  = HALF_W + SCALE_W;
  localparam int PROD_W   = CNT_W + SCALE_W;
  localparam int NUM_CELLS = PROD_W;
  localparam int MUL_STAGES = 2;
  localparam int DEPTH    = NUM_CELLS + MUL_STAGES;
  localparam int OCC_W    = $clog2(DEPTH + 1);

  localparam logic [SCALE_W-1:0] NS_PER_SEC      = SCALE_W'(1000000000);
  localparam logic [FREQ_W-1:0]  DEFAULT_FREQ_HZ = FREQ_W'(62500000);

  typedef struct packed {
    logic [FREQ_W-1:0] rem;
    logic [PROD_W-1:0] work;
  } cell_t;

endpackage

`default_nettype wire

### hw/rtl/c2ns_mul.sv
// ----------------------------------------------------------------------------
// c2ns_mul
// Two-stage scaler: count times one billion, as two half products and a sum.
// ----------------------------------------------------------------------------
`default_nettype none

module c2ns_mul
  import c2ns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CNT_W-1:0]  in_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PROD_W-1:0] out_prod
);

  logic               a_valid_r;
  logic [PPROD_W-1:0] plo_r, phi_r;
  logic [PPROD_W-1:0] plo_nxt, phi_nxt;
  logic               b_valid_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               a_ready, b_ready;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  assign plo_nxt = {{SCALE_W{1'b0}}, in_count[HALF_W-1:0]}
                 * {{HALF_W{1'b0}}, NS_PER_SEC};
  assign phi_nxt = {{SCALE_W{1'b0}}, in_count[CNT_W-1:HALF_W]}
                 * {{HALF_W{1'b0}}, NS_PER_SEC};
  assign prod_nxt = {phi_r, {HALF_W{1'b0}}}
                  + {{(PROD_W-PPROD_W){1'b0}}, plo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (b_ready && a_valid_r) prod_r <= prod_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_prod  = prod_r;

endmodule

`default_nettype wire

### hw/rtl/c2ns_div_cell.sv
// ----------------------------------------------------------------------------
// c2ns_div_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module c2ns_div_cell
  import c2ns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FREQ_W-1:0] freq,
  input  logic              in_valid,
  output logic              in_ready,
  input  cell_t             in_cell,
  output logic              out_valid,
  input  logic              out_ready,
  output cell_t             out_cell
);

  logic          valid_r;
  cell_t         cell_r, cell_nxt;
  logic [FREQ_W:0] partial, diff;
  logic          ge;

  assign in_ready = !valid_r || out_ready;

  assign partial = {in_cell.rem, in_cell.work[PROD_W-1]};
  assign diff    = partial - {1'b0, freq};
  assign ge      = partial >= {1'b0, freq};

  always_comb begin
    cell_nxt.rem  = ge ? diff[FREQ_W-1:0] : partial[FREQ_W-1:0];
    cell_nxt.work = {in_cell.work[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) cell_r <= cell_nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

`default_nettype wire

### hw/rtl/counter_to_nanoseconds_core.sv
// ----------------------------------------------------------------------------
// counter_to_nanoseconds_core
// Counter reading to nanoseconds: floor(count * 1e9 / freq) mod 2^64.
//
//   channel | direction | payload
//   in_     | in        | in_count_value  [63:0]
//   out_    | out       | out_nanoseconds [63:0]
//   cfg_    | in        | cfg_data        [31:0]  counter frequency in Hz
//
// One transfer per cycle in each direction while the output is not stalled; two scaler
// stages, then a row of 94 restoring division cells, one quotient bit each.
// Reset loads 62.5 MHz; a written zero also selects 62.5 MHz.
// A stalled output holds the last cell; bubbles in the row still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_to_nanoseconds_core
  import c2ns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CNT_W-1:0]  in_count_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  out_nanoseconds,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FREQ_W-1:0] cfg_data
);

  logic [FREQ_W-1:0] freq_r;
  logic [PROD_W-1:0] prod;
  logic              cell_valid [0:NUM_CELLS];
  logic              cell_ready [0:NUM_CELLS];
  cell_t             cell_data  [0:NUM_CELLS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= DEFAULT_FREQ_HZ;
    end else if (cfg_valid) begin
      freq_r <= (cfg_data == '0) ? DEFAULT_FREQ_HZ : cfg_data;
    end
  end

  c2ns_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_count  (in_count_value),
    .out_valid (cell_valid[0]),
    .out_ready (cell_ready[0]),
    .out_prod  (prod)
  );

  assign cell_data[0] = {{FREQ_W{1'b0}}, prod};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    c2ns_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .freq      (freq_r),
      .in_valid  (cell_valid[i]),
      .in_ready  (cell_ready[i]),
      .in_cell   (cell_data[i]),
      .out_valid (cell_valid[i+1]),
      .out_ready (cell_ready[i+1]),
      .out_cell  (cell_data[i+1])
    );
  end

  assign cell_ready[NUM_CELLS] = out_ready;
  assign out_valid       = cell_valid[NUM_CELLS];
  assign out_nanoseconds = cell_data[NUM_CELLS].work[CNT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/c2ns_checker.sv
// ----------------------------------------------------------------------------
// c2ns_checker
// Port-level checks on the converter: occupancy, reset and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module c2ns_checker
  import c2ns_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CNT_W-1:0] out_nanoseconds
);

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_xfer && !out_xfer) occ_nxt = occ_r + OCC_W'(1);
    if (!in_xfer && out_xfer) occ_nxt = occ_r - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid right after reset");

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0) else $error("result without pending transfer");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH)) else $error("more items in flight than stages");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nanoseconds))
    else $error("stalled result changed");

endmodule

bind counter_to_nanoseconds_core c2ns_checker u_c2ns_checker (.*);

`default_nettype wire
